FILE: design/sfrp_pkg.sv
// Package for the sensor frame ring parser: item structs, FSM state type,
// command/status codes, header bytes and default sizes. No dependencies.
package sfrp_pkg;

    // Default sizes, handed to the top level parameters
    localparam int RING_BYTES_DEF  = 24;
    localparam int FRAME_BYTES_DEF = 24;

    // Checksum accumulator: up to 257 bytes of 255 stay below 2^16
    localparam int SUM_W = 16;

    // Frame layout: three big-endian words start at byte 4
    localparam int PM_FIRST = 4;
    localparam int PM_BYTES = 6;

    localparam logic [7:0] HDR_FIRST  = 8'h42;  // 'B'
    localparam logic [7:0] HDR_SECOND = 8'h4D;  // 'M'

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_HDR  = 2'd1;
    localparam logic [1:0] STAT_BAD_SUM = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pm_small;
        logic [15:0] pm_fine;
        logic [15:0] pm_coarse;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FRAME
    } t_state;

endpackage

FILE: design/sensor_frame_ring_parser_core.sv
// Top level of the sensor frame ring parser: command sequencer and checksum.
// Depends on sfrp_pkg and sfrp_ring.
//
//  channel | ports                          | direction | flow control
//  --------+--------------------------------+-----------+---------------------------
//  item in | start, i_item (cmd, rx_byte)   | in        | taken when start & !busy
//  result  | o_done, o_result (status, pm_*)| out       | one-cycle strobe, no stall
//
// A byte write (cmd 0) leaves busy low and no result follows.
// A sample request (cmd 1) scans ring slots from 0 for 'B', then streams
// FRAME_BYTES bytes from there through the single ring read port.
// The result strobe o_done is high in the first cycle with busy low again; a
// new item may be started in that same cycle. The receiver cannot hold a
// result off.
// Reset (synchronous, active low) clears the ring through per-slot valid bits,
// the write slot and the retained concentration words; no clearing pass.
module sensor_frame_ring_parser_core
    import sfrp_pkg::*;
#(
    parameter int RING_BYTES  = RING_BYTES_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    localparam int AW = $clog2(RING_BYTES);
    localparam int OW = $clog2(FRAME_BYTES + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_BYTES - 1);
    localparam logic [OW-1:0] OFF_END   = OW'(FRAME_BYTES);
    localparam logic [OW-1:0] OFF_CHK_H = OW'(FRAME_BYTES - 2);
    localparam logic [OW-1:0] OFF_CHK_L = OW'(FRAME_BYTES - 1);
    localparam logic [OW-1:0] OFF_HDR2  = OW'(1);
    localparam logic [OW-1:0] OFF_PM_LO = OW'(PM_FIRST);
    localparam logic [OW-1:0] OFF_PM_HI = OW'(PM_FIRST + PM_BYTES - 1);

    t_state r_state, n_state;

    // ring port
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // control
    logic [AW-1:0] r_wslot;
    logic          r_pend;      // read data for r_pidx / r_roff arrives this cycle
    logic          r_scan_last; // last slot already issued during scan
    logic [AW-1:0] r_idx;       // next scan slot
    logic [AW-1:0] r_pidx;      // slot of the data now returning
    logic [AW-1:0] r_ptr;       // next frame slot (wrapping)
    logic [OW-1:0] r_off;       // next frame offset to issue
    logic [OW-1:0] r_roff;      // frame offset of returning data
    logic          r_done;
    t_out_item     r_out;

    // frame datapath
    logic [SUM_W-1:0] r_sum;
    logic [7:0]       r_chk_hi;
    logic             r_hdr_ok;
    logic [7:0]       r_pm_b [PM_BYTES];
    logic [15:0]      r_last_small, r_last_fine, r_last_coarse;

    logic accept;
    logic hit;
    logic scan_miss;
    logic frame_end;
    logic sum_ok;
    logic [AW-1:0] ptr_inc;

    assign accept    = start && !busy;
    assign hit       = (r_state == ST_SCAN) && r_pend && (rd_data == HDR_FIRST);
    assign scan_miss = (r_state == ST_SCAN) && r_pend && !hit && (r_pidx == LAST_SLOT);
    assign frame_end = (r_state == ST_FRAME) && r_pend && (r_roff == OFF_CHK_L);
    assign sum_ok    = (r_sum == {r_chk_hi, rd_data});
    assign ptr_inc   = (r_ptr == LAST_SLOT) ? '0 : r_ptr + AW'(1);

    // ---------------------------------------------------------------
    // Ring storage. Writes happen only in idle, reads only while busy,
    // so the same slot is never written and read in one cycle.
    // ---------------------------------------------------------------
    sfrp_ring #(
        .DEPTH (RING_BYTES),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wslot),
        .i_wr_data (i_item.rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_item.cmd == CMD_SAMPLE) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_state = ST_FRAME;
                end else if (scan_miss) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FRAME: begin
                if (frame_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // State outputs: ring port control
    // ---------------------------------------------------------------
    always_comb begin
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        case (r_state)
            ST_IDLE: begin
                wr_en = accept && (i_item.cmd == CMD_WRITE);
            end
            ST_SCAN: begin
                // stop issuing once a header is seen
                rd_en   = !r_scan_last && !hit;
                rd_addr = r_idx;
            end
            ST_FRAME: begin
                rd_en   = (r_off != OFF_END);
                rd_addr = r_ptr;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_wslot       <= '0;
            r_pend        <= 1'b0;
            r_scan_last   <= 1'b0;
            r_done        <= 1'b0;
            r_last_small  <= '0;
            r_last_fine   <= '0;
            r_last_coarse <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            r_pend  <= rd_en;

            if (wr_en) begin
                r_wslot <= (r_wslot == LAST_SLOT) ? '0 : r_wslot + AW'(1);
            end

            if (r_state == ST_IDLE) begin
                r_scan_last <= 1'b0;
            end else if (r_state == ST_SCAN && rd_en && r_idx == LAST_SLOT) begin
                r_scan_last <= 1'b1;
            end

            if (scan_miss) begin
                r_done <= 1'b1;
            end

            if (frame_end) begin
                r_done <= 1'b1;
                if (r_hdr_ok && sum_ok) begin
                    r_last_small  <= {r_pm_b[0], r_pm_b[1]};
                    r_last_fine   <= {r_pm_b[2], r_pm_b[3]};
                    r_last_coarse <= {r_pm_b[4], r_pm_b[5]};
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers (no reset needed)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_idx <= '0;
        end else if (r_state == ST_SCAN && rd_en && r_idx != LAST_SLOT) begin
            r_idx <= r_idx + AW'(1);
        end

        if (r_state == ST_SCAN && rd_en) begin
            r_pidx <= r_idx;
        end

        if (hit) begin
            // frame starts at the 'B' slot
            r_ptr    <= r_pidx;
            r_off    <= '0;
            r_sum    <= '0;
            r_hdr_ok <= 1'b0;
        end else if (r_state == ST_FRAME) begin
            if (rd_en) begin
                r_ptr  <= ptr_inc;
                r_off  <= r_off + OW'(1);
                r_roff <= r_off;
            end
            if (r_pend) begin
                if (r_roff == OFF_HDR2) begin
                    r_hdr_ok <= (rd_data == HDR_SECOND);
                end
                if (r_roff < OFF_CHK_H) begin
                    r_sum <= r_sum + SUM_W'(rd_data);
                end
                if (r_roff inside {[OFF_PM_LO:OFF_PM_HI]}) begin
                    r_pm_b[3'(r_roff - OFF_PM_LO)] <= rd_data;
                end
                if (r_roff == OFF_CHK_H) begin
                    r_chk_hi <= rd_data;
                end
            end
        end

        if (scan_miss) begin
            r_out.status    <= STAT_NO_HDR;
            r_out.pm_small  <= r_last_small;
            r_out.pm_fine   <= r_last_fine;
            r_out.pm_coarse <= r_last_coarse;
        end else if (frame_end) begin
            if (!r_hdr_ok) begin
                r_out.status    <= STAT_NO_HDR;
                r_out.pm_small  <= r_last_small;
                r_out.pm_fine   <= r_last_fine;
                r_out.pm_coarse <= r_last_coarse;
            end else if (sum_ok) begin
                r_out.status    <= STAT_OK;
                r_out.pm_small  <= {r_pm_b[0], r_pm_b[1]};
                r_out.pm_fine   <= {r_pm_b[2], r_pm_b[3]};
                r_out.pm_coarse <= {r_pm_b[4], r_pm_b[5]};
            end else begin
                r_out.status    <= STAT_BAD_SUM;
                r_out.pm_small  <= r_last_small;
                r_out.pm_fine   <= r_last_fine;
                r_out.pm_coarse <= r_last_coarse;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == STAT_OK || o_result.status == STAT_NO_HDR ||
                    o_result.status == STAT_BAD_SUM))
        else $error("undefined status code reported");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_SAMPLE) |=> busy)
        else $error("sample request did not start the scan");

    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_WRITE) |=> (!busy && !o_done))
        else $error("byte write caused busy or a result");

endmodule

FILE: design/sfrp_ring.sv
// Byte ring storage: one write port, one registered read port.
// Per-entry valid bits give zero for slots never written since reset.
// Depends on sfrp_pkg for the default depth.
module sfrp_ring
    import sfrp_pkg::*;
#(
    parameter int DEPTH = RING_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 8'd0;

endmodule

FILE: sim/tb_sensor_frame_ring_parser_core.sv
`timescale 1ns / 1ps
// Testbench for sensor_frame_ring_parser_core: byte writes and sample requests
// checked against a behavioral copy of the ring parser. Depends on sfrp_pkg.
module tb_sensor_frame_ring_parser_core;
    import sfrp_pkg::*;

    localparam int RING        = RING_BYTES_DEF;
    localparam int FRAME       = FRAME_BYTES_DEF;
    localparam int ITEM_TARGET = 1750;
    localparam int DRAIN_WAIT  = 60;   // a bit more than one full scan + frame pass

    // Payload styles for generated frames
    typedef enum int {
        FILL_CLEAN,   // random, but no stray 'B' in the payload
        FILL_RAW,     // fully random payload
        FILL_MAX,     // all 0xFF, largest checksum
        FILL_ZERO     // all 0x00
    } t_fill;

    // Tracks ring contents and retained words, and holds the readings owed by
    // the block in request order.
    class ring_reading_model;
        logic [7:0]  ring [RING];
        int unsigned wr_slot;
        logic [15:0] held_small, held_fine, held_coarse;
        t_out_item   pending_readings [$];
        int unsigned errors, n_writes, n_checked, n_ok, n_no_hdr, n_bad_sum;

        function new();
            foreach (ring[i]) ring[i] = 8'h00;
            wr_slot     = 0;
            held_small  = '0;
            held_fine   = '0;
            held_coarse = '0;
        endfunction

        // Called for every accepted item, in acceptance order
        function void note_item(t_in_item it);
            int unsigned hdr;
            bit          found;
            int unsigned sum;
            logic [15:0] trailer;
            t_out_item   want;
            if (it.cmd == CMD_WRITE) begin
                ring[wr_slot] = it.rx_byte;
                wr_slot = (wr_slot + 1) % RING;
                n_writes++;
                return;
            end
            found = 1'b0;
            hdr   = 0;
            for (int i = 0; i < RING; i++) begin
                if (!found && ring[i] == HDR_FIRST) begin
                    hdr   = i;
                    found = 1'b1;
                end
            end
            // only the first 'B' counts; its 'M' may sit in slot 0 after a wrap
            if (!found || ring[(hdr + 1) % RING] != HDR_SECOND) begin
                want.status = STAT_NO_HDR;
            end else begin
                sum = 0;
                for (int i = 0; i < FRAME - 2; i++) sum += ring[(hdr + i) % RING];
                trailer = {ring[(hdr + FRAME - 2) % RING], ring[(hdr + FRAME - 1) % RING]};
                if (sum == trailer) begin
                    held_small  = {ring[(hdr + PM_FIRST) % RING],
                                   ring[(hdr + PM_FIRST + 1) % RING]};
                    held_fine   = {ring[(hdr + PM_FIRST + 2) % RING],
                                   ring[(hdr + PM_FIRST + 3) % RING]};
                    held_coarse = {ring[(hdr + PM_FIRST + 4) % RING],
                                   ring[(hdr + PM_FIRST + 5) % RING]};
                    want.status = STAT_OK;
                end else begin
                    want.status = STAT_BAD_SUM;
                end
            end
            want.pm_small  = held_small;
            want.pm_fine   = held_fine;
            want.pm_coarse = held_coarse;
            pending_readings.push_back(want);
        endfunction

        function void check_reading(t_out_item got);
            t_out_item want;
            if (pending_readings.size() == 0) begin
                errors++;
                $error("unexpected reading: status %0d small %h fine %h coarse %h",
                       got.status, got.pm_small, got.pm_fine, got.pm_coarse);
                return;
            end
            want = pending_readings.pop_front();
            n_checked++;
            case (want.status)
                STAT_OK:     n_ok++;
                STAT_NO_HDR: n_no_hdr++;
                default:     n_bad_sum++;
            endcase
            if (got.status !== want.status) begin
                errors++;
                $error("status: expected %0d, got %0d", want.status, got.status);
            end
            if (got.pm_small !== want.pm_small) begin
                errors++;
                $error("pm_small: expected %h, got %h", want.pm_small, got.pm_small);
            end
            if (got.pm_fine !== want.pm_fine) begin
                errors++;
                $error("pm_fine: expected %h, got %h", want.pm_fine, got.pm_fine);
            end
            if (got.pm_coarse !== want.pm_coarse) begin
                errors++;
                $error("pm_coarse: expected %h, got %h", want.pm_coarse, got.pm_coarse);
            end
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    ring_reading_model readings = new();
    int unsigned       n_items;
    int unsigned       no_idle_left;

    sensor_frame_ring_parser_core #(
        .RING_BYTES (RING),
        .FRAME_BYTES(FRAME)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: a strobed reading is taken at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) readings.check_reading(o_result);
    end

    // Random idle gap, with occasional back-to-back stretches; start stays
    // high across items when there is no gap.
    task automatic send_item(input logic cmd, input logic [7:0] data);
        t_in_item it;
        int       gap;
        it.cmd     = cmd;
        it.rx_byte = data;
        if (no_idle_left > 0) begin
            no_idle_left--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            no_idle_left = $urandom_range(10, 60);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 12);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        readings.note_item(it);
        n_items++;
    endtask

    // Header-heavy noise so that lone 'B' and 'M' bytes show up often
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return HDR_FIRST;
            1:       return HDR_SECOND;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Builds a frame with a correct checksum, optionally flips one bit, and
    // writes its first 'count' bytes.
    task automatic send_frame(input t_fill fill, input int count, input bit corrupt);
        logic [7:0]  fr [FRAME];
        int unsigned sum;
        int          idx;
        int          bitpos;
        fr[0] = HDR_FIRST;
        fr[1] = HDR_SECOND;
        for (int i = 2; i < FRAME - 2; i++) begin
            case (fill)
                FILL_MAX:  fr[i] = 8'hFF;
                FILL_ZERO: fr[i] = 8'h00;
                FILL_RAW:  fr[i] = 8'($urandom_range(0, 255));
                default: begin
                    fr[i] = 8'($urandom_range(0, 255));
                    if (fr[i] == HDR_FIRST) fr[i] = ~fr[i];
                end
            endcase
        end
        sum = 0;
        for (int i = 0; i < FRAME - 2; i++) sum += fr[i];
        fr[FRAME - 2] = sum[15:8];
        fr[FRAME - 1] = sum[7:0];
        if (corrupt) begin
            idx     = $urandom_range(0, FRAME - 1);
            bitpos  = $urandom_range(0, 7);
            fr[idx] = fr[idx] ^ (8'h01 << bitpos);
        end
        for (int k = 0; k < count; k++) send_item(CMD_WRITE, fr[k]);
    endtask

    initial begin
        int    kind;
        int    n;
        t_fill fill;
        n_items      = 0;
        no_idle_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty ring, lone 'B', header with bad checksum, then a
        // good all-0xFF frame that wraps past the end of the ring
        send_item(CMD_SAMPLE, 8'hFF);
        send_item(CMD_WRITE, HDR_FIRST);
        send_item(CMD_SAMPLE, 8'h00);
        send_item(CMD_WRITE, HDR_SECOND);
        send_item(CMD_SAMPLE, 8'h5A);
        send_frame(FILL_MAX, FRAME, 1'b0);
        send_item(CMD_SAMPLE, 8'hA5);

        // Random: mostly whole frames at random ring offsets, plus partial
        // frames, noise and repeated requests
        while (n_items < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            n    = $urandom_range(0, 99);
            if (n < 70) begin
                fill = FILL_CLEAN;
            end else if (n < 90) begin
                fill = FILL_RAW;
            end else if (n < 95) begin
                fill = FILL_MAX;
            end else begin
                fill = FILL_ZERO;
            end
            if (kind < 6) begin
                n = $urandom_range(0, RING - 1);
                for (int k = 0; k < n; k++) send_item(CMD_WRITE, noise_byte());
                send_frame(fill, FRAME, $urandom_range(0, 4) == 0);
                send_item(CMD_SAMPLE, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0) begin
                    send_item(CMD_SAMPLE, 8'($urandom_range(0, 255)));
                end
            end else if (kind < 8) begin
                send_frame(fill, $urandom_range(1, FRAME - 1), $urandom_range(0, 4) == 0);
                send_item(CMD_SAMPLE, 8'($urandom_range(0, 255)));
            end else if (kind == 8) begin
                n = $urandom_range(1, 30);
                for (int k = 0; k < n; k++) send_item(CMD_WRITE, noise_byte());
                send_item(CMD_SAMPLE, 8'($urandom_range(0, 255)));
            end else begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) send_item(CMD_SAMPLE, 8'($urandom_range(0, 255)));
            end
        end
        start <= 1'b0;

        while (readings.pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d items: %0d byte writes, %0d sample requests checked.",
                 n_items, readings.n_writes, readings.n_checked);
        $display("Readings: %0d ok, %0d header not found, %0d checksum mismatch.",
                 readings.n_ok, readings.n_no_hdr, readings.n_bad_sum);
        if (readings.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Slowest correct run is near 1.2 ms
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
